@@ src/segment_intersection_test_assert.svh @@
// assertion macros for the segment intersection test
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SIT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ src/sit_pkg.sv @@
// shared widths and payload types of the segment intersection test
`default_nettype none
package sit_pkg;
   localparam int CW    = 32;
   localparam int DW    = CW + 1;
   localparam int PW    = 2 * DW;
   localparam int XW    = PW + 1;
   localparam int QW    = CW + 1;
   localparam int SW    = CW + 2;
   localparam int NCELL = CW;

   typedef logic [CW-1:0] coord_type;

   typedef struct packed {
      logic            hit;
      coord_type       p1x;
      coord_type       p1y;
      logic [XW-1:0]   d;
      logic [XW-1:0]   a;
      logic [CW-1:0]   mx;
      logic [CW-1:0]   my;
      logic            negx;
      logic            negy;
      logic [XW-1:0]   remx;
      logic [XW-1:0]   remy;
      logic [QW-1:0]   qx;
      logic [QW-1:0]   qy;
   } div_type;
endpackage
`default_nettype wire

@@ src/sit_cross.sv @@
// differences, cross products, sign normalization and range test
`default_nettype none
module sit_cross (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire sit_pkg::coord_type p1x,
   input  wire sit_pkg::coord_type p1y,
   input  wire sit_pkg::coord_type p2x,
   input  wire sit_pkg::coord_type p2y,
   input  wire sit_pkg::coord_type q1x,
   input  wire sit_pkg::coord_type q1y,
   input  wire sit_pkg::coord_type q2x,
   input  wire sit_pkg::coord_type q2y,
   output logic                   out_valid,
   output sit_pkg::div_type       out_item
);
   logic [3:0] v_ff;
   logic       v5_ff;

   logic signed [sit_pkg::DW-1:0] rx_ff, ry_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [sit_pkg::DW-1:0] rx_in, ry_in, sx_in, sy_in, ex_in, ey_in;
   sit_pkg::coord_type p1x_ff [4];
   sit_pkg::coord_type p1y_ff [4];
   logic [sit_pkg::CW-1:0] mx_ff [3];
   logic [sit_pkg::CW-1:0] my_ff [3];
   logic [2:0] negx_ff, negy_ff;

   logic signed [sit_pkg::PW-1:0] pd0_ff, pd1_ff, pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic [sit_pkg::XW-1:0] d3_ff, a3_ff, b3_ff, d3_in, a3_in, b3_in;
   logic [sit_pkg::XW-1:0] d4_ff, a4_ff, b4_ff, d4_in, a4_in, b4_in;
   logic dz_ff, dz_in, hit_ff, hit_in;
   logic [sit_pkg::XW-1:0] d5_ff, a5_ff;

   assign rx_in = $signed({p2x[sit_pkg::CW-1], p2x}) - $signed({p1x[sit_pkg::CW-1], p1x});
   assign ry_in = $signed({p2y[sit_pkg::CW-1], p2y}) - $signed({p1y[sit_pkg::CW-1], p1y});
   assign sx_in = $signed({q2x[sit_pkg::CW-1], q2x}) - $signed({q1x[sit_pkg::CW-1], q1x});
   assign sy_in = $signed({q2y[sit_pkg::CW-1], q2y}) - $signed({q1y[sit_pkg::CW-1], q1y});
   assign ex_in = $signed({q1x[sit_pkg::CW-1], q1x}) - $signed({p1x[sit_pkg::CW-1], p1x});
   assign ey_in = $signed({q1y[sit_pkg::CW-1], q1y}) - $signed({p1y[sit_pkg::CW-1], p1y});

   assign d3_in = {pd0_ff[sit_pkg::PW-1], pd0_ff} - {pd1_ff[sit_pkg::PW-1], pd1_ff};
   assign a3_in = {pa0_ff[sit_pkg::PW-1], pa0_ff} - {pa1_ff[sit_pkg::PW-1], pa1_ff};
   assign b3_in = {pb0_ff[sit_pkg::PW-1], pb0_ff} - {pb1_ff[sit_pkg::PW-1], pb1_ff};

   // make d non-negative, negating a and b with it, and flag a zero d
   assign d4_in = d3_ff[sit_pkg::XW-1] ? -d3_ff : d3_ff;
   assign a4_in = d3_ff[sit_pkg::XW-1] ? -a3_ff : a3_ff;
   assign b4_in = d3_ff[sit_pkg::XW-1] ? -b3_ff : b3_ff;
   assign dz_in = (d3_ff == '0);

   assign hit_in = !dz_ff && !a4_ff[sit_pkg::XW-1] && !b4_ff[sit_pkg::XW-1]
                   && (a4_ff <= d4_ff) && (b4_ff <= d4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v_ff  <= {v_ff[2:0], in_valid};
         v5_ff <= v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         p1x_ff[0] <= p1x;
         p1y_ff[0] <= p1y;

         pd0_ff <= $signed(sit_pkg::PW'(rx_ff)) * $signed(sit_pkg::PW'(sy_ff));
         pd1_ff <= $signed(sit_pkg::PW'(ry_ff)) * $signed(sit_pkg::PW'(sx_ff));
         pa0_ff <= $signed(sit_pkg::PW'(ex_ff)) * $signed(sit_pkg::PW'(sy_ff));
         pa1_ff <= $signed(sit_pkg::PW'(ey_ff)) * $signed(sit_pkg::PW'(sx_ff));
         pb0_ff <= $signed(sit_pkg::PW'(ex_ff)) * $signed(sit_pkg::PW'(ry_ff));
         pb1_ff <= $signed(sit_pkg::PW'(ey_ff)) * $signed(sit_pkg::PW'(rx_ff));
         mx_ff[0]   <= sit_pkg::CW'(rx_ff[sit_pkg::DW-1] ? -rx_ff : rx_ff);
         my_ff[0]   <= sit_pkg::CW'(ry_ff[sit_pkg::DW-1] ? -ry_ff : ry_ff);
         negx_ff[0] <= rx_ff[sit_pkg::DW-1];
         negy_ff[0] <= ry_ff[sit_pkg::DW-1];
         p1x_ff[1]  <= p1x_ff[0];
         p1y_ff[1]  <= p1y_ff[0];

         d3_ff <= d3_in;
         a3_ff <= a3_in;
         b3_ff <= b3_in;
         mx_ff[1]   <= mx_ff[0];
         my_ff[1]   <= my_ff[0];
         negx_ff[1] <= negx_ff[0];
         negy_ff[1] <= negy_ff[0];
         p1x_ff[2]  <= p1x_ff[1];
         p1y_ff[2]  <= p1y_ff[1];

         d4_ff <= d4_in;
         a4_ff <= a4_in;
         b4_ff <= b4_in;
         dz_ff <= dz_in;
         mx_ff[2]   <= mx_ff[1];
         my_ff[2]   <= my_ff[1];
         negx_ff[2] <= negx_ff[1];
         negy_ff[2] <= negy_ff[1];
         p1x_ff[3]  <= p1x_ff[2];
         p1y_ff[3]  <= p1y_ff[2];

         hit_ff <= hit_in;
         d5_ff  <= d4_ff;
         a5_ff  <= a4_ff;
      end
   end

   // stage 5 carries the tail of the pipe for p1, magnitudes and signs
   logic [sit_pkg::CW-1:0] mx5_ff, my5_ff;
   logic negx5_ff, negy5_ff;
   sit_pkg::coord_type p1x5_ff, p1y5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mx5_ff   <= mx_ff[2];
         my5_ff   <= my_ff[2];
         negx5_ff <= negx_ff[2];
         negy5_ff <= negy_ff[2];
         p1x5_ff  <= p1x_ff[3];
         p1y5_ff  <= p1y_ff[3];
      end
   end

   assign out_valid = v5_ff;

   always_comb begin
      out_item      = '0;
      out_item.hit  = hit_ff;
      out_item.p1x  = p1x5_ff;
      out_item.p1y  = p1y5_ff;
      out_item.d    = d5_ff;
      out_item.a    = a5_ff;
      out_item.mx   = mx5_ff;
      out_item.my   = my5_ff;
      out_item.negx = negx5_ff;
      out_item.negy = negy5_ff;
   end
endmodule
`default_nettype wire

@@ src/sit_div_cell.sv @@
// one digit step of the scaled division a*|r|/d for both axes
`default_nettype none
module sit_div_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire sit_pkg::div_type in_item,
   output logic                  out_valid,
   output sit_pkg::div_type      out_item
);
   typedef struct packed {
      logic [sit_pkg::XW-1:0] rem;
      logic [sit_pkg::QW-1:0] q;
   } remq_type;

   function automatic remq_type step(input logic [sit_pkg::XW-1:0] rem,
                                     input logic [sit_pkg::QW-1:0] q,
                                     input logic [sit_pkg::XW-1:0] a,
                                     input logic [sit_pkg::XW-1:0] d,
                                     input logic                   mbit);
      logic [sit_pkg::XW-1:0] t;
      logic [sit_pkg::XW-1:0] d2;
      logic [sit_pkg::QW-1:0] qs;
      remq_type               res;
      t  = {rem[sit_pkg::XW-2:0], 1'b0} + (mbit ? a : '0);
      d2 = {d[sit_pkg::XW-2:0], 1'b0};
      qs = {q[sit_pkg::QW-2:0], 1'b0};
      if (t >= d2) begin
         res.rem = t - d2;
         res.q   = qs + sit_pkg::QW'(2);
      end else if (t >= d) begin
         res.rem = t - d;
         res.q   = qs + sit_pkg::QW'(1);
      end else begin
         res.rem = t;
         res.q   = qs;
      end
      return res;
   endfunction

   logic             valid_ff;
   sit_pkg::div_type item_ff, item_in;
   remq_type         sx, sy;

   assign sx = step(in_item.remx, in_item.qx, in_item.a, in_item.d,
                    in_item.mx[sit_pkg::CW-1]);
   assign sy = step(in_item.remy, in_item.qy, in_item.a, in_item.d,
                    in_item.my[sit_pkg::CW-1]);

   always_comb begin
      item_in      = in_item;
      item_in.remx = sx.rem;
      item_in.qx   = sx.q;
      item_in.remy = sy.rem;
      item_in.qy   = sy.q;
      item_in.mx   = {in_item.mx[sit_pkg::CW-2:0], 1'b0};
      item_in.my   = {in_item.my[sit_pkg::CW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

@@ src/segment_intersection_test.sv @@
// top level of the segment intersection test
`default_nettype none
`include "segment_intersection_test_assert.svh"
// Takes one segment pair per cycle while req_tready is high and returns one result per
// request, in order. Stages: one for differences, one for the six 33x33 products, one
// for the cross product subtraction, one for sign normalization, one for the range
// test, 32 division cells (one quotient digit per bit of |r|) and one output stage
// for offset add and saturation. The whole pipe stalls only while a result waits at
// the output; req_tready then drops. Misses and parallel pairs give hit 0 and zeros.
module segment_intersection_test (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  wire logic [255:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // meet_x, meet_y
   output logic [63:0]       rsp_tdata,
   // hit
   output logic              rsp_tuser
);
   logic adv;
   logic chain_valid [sit_pkg::NCELL+1];
   sit_pkg::div_type chain_item [sit_pkg::NCELL+1];

   logic             out_valid_ff;
   logic             hit_ff, hit_in;
   sit_pkg::coord_type mx_ff, my_ff, mx_in, my_in;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   sit_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .p1x       (req_tdata[31:0]),
      .p1y       (req_tdata[63:32]),
      .p2x       (req_tdata[95:64]),
      .p2y       (req_tdata[127:96]),
      .q1x       (req_tdata[159:128]),
      .q1y       (req_tdata[191:160]),
      .q2x       (req_tdata[223:192]),
      .q2y       (req_tdata[255:224]),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar i = 0; i < sit_pkg::NCELL; i++) begin : g_cell
      sit_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   function automatic sit_pkg::coord_type offset_sat(input sit_pkg::coord_type p1,
                                                     input logic [sit_pkg::QW-1:0] q,
                                                     input logic neg);
      logic [sit_pkg::SW-1:0] pe;
      logic [sit_pkg::SW-1:0] qe;
      logic [sit_pkg::SW-1:0] sum;
      sit_pkg::coord_type     res;
      pe  = {{2{p1[sit_pkg::CW-1]}}, p1};
      qe  = {1'b0, q};
      sum = neg ? pe - qe : pe + qe;
      if (sum[sit_pkg::SW-1:sit_pkg::CW-1] == '0
          || sum[sit_pkg::SW-1:sit_pkg::CW-1] == '1) begin
         res = sum[sit_pkg::CW-1:0];
      end else if (sum[sit_pkg::SW-1]) begin
         res = {1'b1, {(sit_pkg::CW-1){1'b0}}};
      end else begin
         res = {1'b0, {(sit_pkg::CW-1){1'b1}}};
      end
      return res;
   endfunction

   assign hit_in = chain_item[sit_pkg::NCELL].hit;
   assign mx_in  = hit_in ? offset_sat(chain_item[sit_pkg::NCELL].p1x,
                                       chain_item[sit_pkg::NCELL].qx,
                                       chain_item[sit_pkg::NCELL].negx) : '0;
   assign my_in  = hit_in ? offset_sat(chain_item[sit_pkg::NCELL].p1y,
                                       chain_item[sit_pkg::NCELL].qy,
                                       chain_item[sit_pkg::NCELL].negy) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= chain_valid[sit_pkg::NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {my_ff, mx_ff};

   `SIT_ASSERT(a_miss_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "miss with nonzero point")
   `SIT_ASSERT(a_stall_back, rsp_tvalid && !rsp_tready |-> !req_tready, "request taken while result stalled")
   `SIT_ASSERT_RST(a_reset_empty, $past(reset) |-> !rsp_tvalid, "result valid right after reset")
endmodule
`default_nettype wire
